@@ sv/wall_segment_ray_caster_defines.svh @@
// Assertion macros for the ray caster RTL.
`ifndef WALL_SEGMENT_RAY_CASTER_DEFINES_SVH
`define WALL_SEGMENT_RAY_CASTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define WSRC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WSRC_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSRC_ASSERT(lbl, clk, rst, prop, msg)
`define WSRC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ sv/wsrc_pkg.sv @@
package wsrc_pkg;

   localparam int MAX_WALLS_DEF = 32;
   localparam int COLUMNS       = 80;
   localparam int LINES         = 56;
   localparam int HALF_COLS     = COLUMNS / 2;

   localparam logic [7:0]  SPACE_CODE = 8'd32;
   localparam logic [30:0] FAR_DIST   = 31'h7FFF_FFFF;
   localparam logic [4:0]  HALF_CAP   = 5'(LINES / 2 + 1);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   localparam logic REG_FACTOR = 1'b0;
   localparam logic REG_NUDGE  = 1'b1;

   typedef struct packed {
      logic [7:0]         symbol;
      logic signed [31:0] by;
      logic signed [31:0] bx;
      logic signed [31:0] ay;
      logic signed [31:0] ax;
   } wall_entry_type;

   typedef struct packed {
      logic        start;
      logic        neg;
      logic [63:0] dividend;
      logic [33:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic        neg;
      logic [63:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

   typedef logic [63:0] trig_rom_type [360];

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // Signed result of a truncating division from its magnitude and sign.
   function automatic logic signed [31:0] sat_quot(input logic [63:0] q, input logic neg);
      if (neg) begin
         if (q > 64'h8000_0000) begin
            return 32'sh8000_0000;
         end
         return 32'(-q[31:0]);
      end
      if (q > 64'h7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end
      return q[31:0];
   endfunction

   // Heading cos and sin in Q16.16, packed {cos, sin}. Evaluated at elaboration only:
   // Taylor series of the quarter angle in Q30, then two double-angle steps.
   function automatic logic [63:0] trig_pair(input int deg);
      logic [63:0]        q;
      logic [63:0]        x2;
      logic [63:0]        ts;
      logic [63:0]        tc;
      logic signed [63:0] s;
      logic signed [63:0] c;
      logic signed [63:0] s2;
      logic signed [63:0] c2;
      logic signed [63:0] co;
      logic signed [63:0] si;
      q  = (64'(deg) * 64'd10 * (64'd1 << 30) + 64'd1146) / 64'd2292;
      x2 = (q * q + (64'd1 << 29)) >> 30;
      ts = q;
      tc = 64'd1 << 30;
      s  = $signed(q);
      c  = 64'sd1 <<< 30;
      for (int n = 1; n <= 12; n++) begin
         ts = ((ts * x2 + (64'd1 << 29)) >> 30) / 64'((2 * n) * (2 * n + 1));
         tc = ((tc * x2 + (64'd1 << 29)) >> 30) / 64'((2 * n - 1) * (2 * n));
         if ((n % 2) == 1) begin
            s = s - $signed(ts);
            c = c - $signed(tc);
         end else begin
            s = s + $signed(ts);
            c = c + $signed(tc);
         end
      end
      for (int n = 0; n < 2; n++) begin
         s2 = (64'sd2 * s * c + (64'sd1 <<< 29)) >>> 30;
         c2 = (64'sd1 <<< 30) - ((64'sd2 * s * s + (64'sd1 <<< 29)) >>> 30);
         s  = s2;
         c  = c2;
      end
      co = (c + (64'sd1 <<< 13)) >>> 14;
      si = (s + (64'sd1 <<< 13)) >>> 14;
      return {co[31:0], si[31:0]};
   endfunction

   function automatic trig_rom_type build_trig_rom();
      trig_rom_type rom;
      for (int i = 0; i < 360; i++) begin
         rom[i] = trig_pair(i);
      end
      return rom;
   endfunction

   localparam trig_rom_type TRIG_ROM = build_trig_rom();

endpackage

@@ sv/wsrc_wall_mem.sv @@
module wsrc_wall_mem #(
   parameter int MAX_WALLS = 32,
   parameter int AW        = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  wsrc_pkg::wall_entry_type wr_data,
   input  logic                     wr_valid,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic                     rd_valid,
   output wsrc_pkg::wall_entry_type rd_data
);
   import wsrc_pkg::*;

   wall_entry_type wall_ram_ff [MAX_WALLS];
   wall_entry_type rd_data_ff;
   logic [MAX_WALLS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wall_ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= wall_ram_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= wr_valid;
      end
   end

   assign rd_valid = valid_ff[rd_addr];
   assign rd_data  = rd_data_ff;

endmodule

@@ sv/wsrc_div.sv @@
module wsrc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  wsrc_pkg::div_req_type div_req,
   output wsrc_pkg::div_rsp_type div_rsp
);
   import wsrc_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [33:0] rem_ff, rem_in;
   logic [33:0] dsr_ff, dsr_in;
   logic        neg_ff, neg_in;
   logic [34:0] rem_sh;

   // Restoring division, one quotient bit per cycle; the dividend register
   // fills up with the quotient from the bottom.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff, dvd_ff[63]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         neg_in  = div_req.neg;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = 34'(rem_sh - {1'b0, dsr_ff});
            dvd_in = {dvd_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[33:0];
            dvd_in = {dvd_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.neg  = neg_ff;
   assign div_rsp.quot = dvd_ff;

endmodule

@@ sv/wsrc_sqrt.sv @@
module wsrc_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  wsrc_pkg::sqrt_req_type sqrt_req,
   output wsrc_pkg::sqrt_rsp_type sqrt_rsp
);
   import wsrc_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] rad_ff, rad_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   // Digit-by-digit integer square root, two radicand bits per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + bit_ff;
      if (sqrt_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = sqrt_req.radicand;
         res_in  = '0;
         bit_in  = 64'd1 << 62;
      end else if (busy_ff) begin
         if (rad_ff >= trial) begin
            rad_in = rad_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff <= rad_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign sqrt_rsp.busy = busy_ff;
   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = res_ff[31:0];

endmodule

@@ sv/wall_segment_ray_caster.sv @@
// Wall segment ray caster. Write items (tuser 0) store one wall in the wall
// table. A cast item (tuser 1) with a column below 80 walks every table entry
// in order: an enabled wall goes through a shared 32x32 multiplier, a
// one-bit-per-cycle divider (two divisions per wall) and a two-bit-per-cycle
// square root, and one that is skipped early uses fewer of them. The ray slope
// is divided at the start and the height at the end. Only one item is in work
// at a time, and input is taken again as soon as the result sits in the output
// register.
module wall_segment_ray_caster #(
   parameter int MAX_WALLS = wsrc_pkg::MAX_WALLS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // tdata: wall_index[4:0], end_ax[36:5], end_ay[68:37], end_bx[100:69],
   // end_by[132:101], wall_symbol[140:133], wall_enable[141], column[148:142],
   // viewer_x[180:149], viewer_y[212:181], view_angle[221:213], zero fill
   input  logic [223:0] req_tdata,
   // tuser: opcode
   input  logic         req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: column_out[6:0], distance[37:7], symbol[45:38], half_height[50:46],
   // zero fill
   output logic [55:0]  rsp_tdata,
   // tuser: hit
   output logic         rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import wsrc_pkg::*;
`include "wall_segment_ray_caster_defines.svh"

   localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
   localparam int CW = $clog2(MAX_WALLS + 1);

   typedef enum logic [19:0] {
      S_IDLE  = 20'h00001,
      S_RDIV  = 20'h00002,
      S_FETCH = 20'h00004,
      S_LOAD  = 20'h00008,
      S_ROT   = 20'h00010,
      S_CHK   = 20'h00020,
      S_DX    = 20'h00040,
      S_KDIV  = 20'h00080,
      S_KB    = 20'h00100,
      S_B     = 20'h00200,
      S_XDIV  = 20'h00400,
      S_Y     = 20'h00800,
      S_YW    = 20'h01000,
      S_SQ1   = 20'h02000,
      S_SQ2   = 20'h04000,
      S_SQW   = 20'h10000,
      S_HGT   = 20'h20000,
      S_HWAIT = 20'h40000,
      S_OUT   = 20'h80000
   } state_type;

   // Input fields.
   logic [4:0]         f_index;
   wall_entry_type     f_wall;
   logic               f_enable;
   logic [6:0]         f_column;
   logic signed [31:0] f_vx, f_vy;
   logic [8:0]         f_angle;

   assign f_index       = req_tdata[4:0];
   assign f_wall.ax     = req_tdata[36:5];
   assign f_wall.ay     = req_tdata[68:37];
   assign f_wall.bx     = req_tdata[100:69];
   assign f_wall.by     = req_tdata[132:101];
   assign f_wall.symbol = req_tdata[140:133];
   assign f_enable      = req_tdata[141];
   assign f_column      = req_tdata[148:142];
   assign f_vx          = req_tdata[180:149];
   assign f_vy          = req_tdata[212:181];
   assign f_angle       = req_tdata[221:213];

   state_type          state_ff, state_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [6:0]         col_ff, col_in;
   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [8:0]         deg_ff, deg_in;
   logic signed [31:0] co_ff, co_in, si_ff, si_in;
   logic signed [31:0] r_ff, r_in;
   logic signed [31:0] tr_ff [4];
   logic signed [31:0] tr_in [4];
   logic signed [31:0] coord_ff [4];
   logic signed [31:0] coord_in [4];
   logic signed [31:0] k_ff, k_in, x_ff, x_in;
   logic [63:0]        sq_ff, sq_in;
   logic signed [63:0] prod_ff, acc_ff, acc_in;
   logic signed [31:0] mul_a, mul_b;
   logic               found_ff, found_in;
   logic [30:0]        best_ff, best_in;
   logic [7:0]         sym_ff, sym_in;
   logic [4:0]         half_ff, half_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [55:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [31:0]        factor_ff, factor_in;
   logic [15:0]        nudge_ff, nudge_in;

   logic               mem_wr_en, mem_rd_en, mem_rd_valid;
   wall_entry_type     mem_rd_data;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   sqrt_req_type       sqrt_req;
   sqrt_rsp_type       sqrt_rsp;

   logic               accept;
   logic               csr_wr;
   logic [2:0]         pj;
   logic signed [63:0] rot_sum, t64, dx64, dy64, den64;
   logic signed [31:0] b32, y32;
   logic [31:0]        dist32;
   logic [30:0]        dist31;
   logic signed [31:0] xl, xr;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_NUDGE) ? {16'd0, nudge_ff} : factor_ff;

   assign mem_wr_en = accept && (req_tuser == OP_WRITE) && (32'(f_index) < 32'(MAX_WALLS));

   wsrc_wall_mem #(.MAX_WALLS(MAX_WALLS), .AW(AW)) u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (mem_wr_en),
      .wr_addr  (AW'(f_index)),
      .wr_data  (f_wall),
      .wr_valid (f_enable),
      .rd_en    (mem_rd_en),
      .rd_addr  (idx_ff[AW-1:0]),
      .rd_valid (mem_rd_valid),
      .rd_data  (mem_rd_data)
   );

   wsrc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   wsrc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   // Shared multiplier with a registered product.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      deg_in       = deg_ff;
      co_in        = co_ff;
      si_in        = si_ff;
      r_in         = r_ff;
      tr_in        = tr_ff;
      coord_in     = coord_ff;
      k_in         = k_ff;
      x_in         = x_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      sym_in       = sym_ff;
      half_in      = half_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_hit_in   = rsp_hit_ff;
      factor_in    = factor_ff;
      nudge_in     = nudge_ff;
      mem_rd_en    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;
      sqrt_req     = '0;
      pj           = 3'(cnt_ff - 4'd1);
      rot_sum      = '0;
      t64          = '0;
      dx64         = 64'(coord_ff[2]) - 64'(coord_ff[0]);
      dy64         = 64'(coord_ff[3]) - 64'(coord_ff[1]);
      den64        = '0;
      b32          = '0;
      y32          = sat32(prod_ff >>> 16);
      dist32       = sqrt_rsp.root;
      dist31       = (dist32 > 32'(FAR_DIST)) ? FAR_DIST : dist32[30:0];
      xl           = (coord_ff[0] < coord_ff[2]) ? coord_ff[0] : coord_ff[2];
      xr           = (coord_ff[0] < coord_ff[2]) ? coord_ff[2] : coord_ff[0];

      if (csr_wr) begin
         if (csr_paddr[2] == REG_FACTOR) begin
            factor_in = csr_pwdata;
         end else begin
            nudge_in = csr_pwdata[15:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_tuser == OP_CAST)) begin
               col_in   = f_column;
               vx_in    = f_vx;
               vy_in    = f_vy;
               deg_in   = (f_angle >= 9'd360) ? 9'(f_angle - 9'd360) : f_angle;
               found_in = 1'b0;
               best_in  = FAR_DIST;
               sym_in   = SPACE_CODE;
               if (32'(f_column) < 32'(2 * HALF_COLS)) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = 64'(HALF_COLS) << 16;
                  if (32'(f_column) < 32'(HALF_COLS)) begin
                     div_req.neg     = 1'b1;
                     div_req.divisor = 34'(HALF_COLS) - 34'(f_column);
                  end else begin
                     div_req.divisor = 34'(f_column) + 34'd1 - 34'(HALF_COLS);
                  end
                  state_in = S_RDIV;
               end else begin
                  state_in = S_HGT;
               end
            end
         end
         S_RDIV: begin
            co_in = TRIG_ROM[deg_ff][63:32];
            si_in = TRIG_ROM[deg_ff][31:0];
            if (div_rsp.done) begin
               r_in     = sat_quot(div_rsp.quot, div_rsp.neg);
               idx_in   = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (idx_ff == CW'(MAX_WALLS)) begin
               state_in = S_HGT;
            end else if (mem_rd_valid) begin
               mem_rd_en = 1'b1;
               state_in  = S_LOAD;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_LOAD: begin
            tr_in[0] = sat32(64'(mem_rd_data.ax) - 64'(vx_ff));
            tr_in[1] = sat32(64'(mem_rd_data.ay) - 64'(vy_ff));
            tr_in[2] = sat32(64'(mem_rd_data.bx) - 64'(vx_ff));
            tr_in[3] = sat32(64'(mem_rd_data.by) - 64'(vy_ff));
            cnt_in   = '0;
            state_in = S_ROT;
         end
         S_ROT: begin
            // Eight products in order: ax*co, ay*si, ax*si, ay*co, then the same for the
            // second endpoint; each pair is combined once its second product is registered.
            mul_a = tr_ff[{cnt_ff[2], cnt_ff[0]}];
            mul_b = (cnt_ff[1] ^ cnt_ff[0]) ? si_ff : co_ff;
            if (cnt_ff != 4'd0) begin
               if (!pj[0]) begin
                  acc_in = prod_ff;
               end else begin
                  rot_sum = pj[1] ? (acc_ff + prod_ff) : (acc_ff - prod_ff);
                  coord_in[pj[2:1]] = sat32(rot_sum >>> 16);
               end
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (coord_ff[1][31] && coord_ff[3][31]) begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_FETCH;
            end else begin
               if (coord_ff[0] == coord_ff[2]) begin
                  coord_in[0] = sat32(64'(coord_ff[0]) - 64'(nudge_ff));
               end
               state_in = S_DX;
            end
         end
         S_DX: begin
            if (dx64 == 64'sd0) begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_FETCH;
            end else begin
               div_req.start    = 1'b1;
               div_req.neg      = dy64[63] ^ dx64[63];
               div_req.dividend = abs64(dy64) << 16;
               div_req.divisor  = 34'(abs64(dx64));
               state_in         = S_KDIV;
            end
         end
         S_KDIV: begin
            if (div_rsp.done) begin
               k_in     = sat_quot(div_rsp.quot, div_rsp.neg);
               state_in = S_KB;
            end
         end
         S_KB: begin
            mul_a    = k_ff;
            mul_b    = coord_ff[0];
            state_in = S_B;
         end
         S_B: begin
            t64   = 64'(coord_ff[1]) - (prod_ff >>> 16);
            b32   = sat32(t64);
            den64 = 64'(r_ff) - 64'(k_ff);
            if (den64 == 64'sd0) begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_FETCH;
            end else begin
               div_req.start    = 1'b1;
               div_req.neg      = b32[31] ^ den64[63];
               div_req.dividend = abs64(64'(b32)) << 16;
               div_req.divisor  = 34'(abs64(den64));
               state_in         = S_XDIV;
            end
         end
         S_XDIV: begin
            if (div_rsp.done) begin
               x_in     = sat_quot(div_rsp.quot, div_rsp.neg);
               state_in = S_Y;
            end
         end
         S_Y: begin
            mul_a    = r_ff;
            mul_b    = x_ff;
            state_in = S_YW;
         end
         S_YW: begin
            if (y32[31] || (x_ff < xl) || (x_ff > xr)) begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_FETCH;
            end else begin
               mul_a    = y32;
               mul_b    = y32;
               state_in = S_SQ1;
            end
         end
         S_SQ1: begin
            // The product register holds y*y here and x*x in S_SQ2.
            sq_in    = prod_ff;
            mul_a    = x_ff;
            mul_b    = x_ff;
            state_in = S_SQ2;
         end
         S_SQ2: begin
            sqrt_req.start    = 1'b1;
            sqrt_req.radicand = sq_ff + prod_ff;
            state_in          = S_SQW;
         end
         S_SQW: begin
            if (sqrt_rsp.done) begin
               if (!found_ff || (dist31 < best_ff)) begin
                  found_in = 1'b1;
                  best_in  = dist31;
                  sym_in   = mem_rd_data.symbol;
               end
               idx_in   = idx_ff + CW'(1);
               state_in = S_FETCH;
            end
         end
         S_HGT: begin
            if (found_ff && (best_ff != 31'd0)) begin
               div_req.start    = 1'b1;
               div_req.dividend = 64'(LINES) * 64'(factor_ff);
               div_req.divisor  = 34'(best_ff);
               state_in         = S_HWAIT;
            end else begin
               half_in  = found_ff ? HALF_CAP : 5'd0;
               state_in = S_OUT;
            end
         end
         S_HWAIT: begin
            if (div_rsp.done) begin
               half_in  = (div_rsp.quot > 64'(HALF_CAP)) ? HALF_CAP : div_rsp.quot[4:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = found_ff;
               rsp_data_in  = {5'd0, half_ff, sym_ff, best_ff, col_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         factor_ff    <= 32'd65536;
         nudge_ff     <= 16'd66;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         factor_ff    <= factor_in;
         nudge_ff     <= nudge_in;
      end
      col_ff      <= col_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      deg_ff      <= deg_in;
      co_ff       <= co_in;
      si_ff       <= si_in;
      r_ff        <= r_in;
      tr_ff       <= tr_in;
      coord_ff    <= coord_in;
      k_ff        <= k_in;
      x_ff        <= x_in;
      sq_ff       <= sq_in;
      acc_ff      <= acc_in;
      best_ff     <= best_in;
      sym_ff      <= sym_in;
      half_ff     <= half_in;
      rsp_data_ff <= rsp_data_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

   `WSRC_ASSERT_NR(a_rsp_reset, clock, reset |=> !rsp_valid_ff, "result valid after reset")
   `WSRC_ASSERT(a_rsp_src, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT), "result loaded outside output step")
   `WSRC_ASSERT(a_nohit, clock, reset, (rsp_valid_ff && !rsp_hit_ff) |-> ((rsp_data_ff[50:46] == 5'd0) && (rsp_data_ff[45:38] == SPACE_CODE)), "no-hit result carries height or symbol")
   `WSRC_ASSERT(a_div_busy, clock, reset, div_req.start |-> !div_rsp.busy, "divider restarted while busy")

endmodule

@@ verif/wall_segment_ray_caster_tb.sv @@
module wall_segment_ray_caster_tb;
   import wsrc_pkg::*;

   localparam int  RANDOM_ITEMS = 1880;
   localparam int  MAX_LIVE     = 4;
   localparam longint CYCLE_LIMIT = 12000000;

   typedef struct {
      logic        opcode;
      logic [4:0]  wall_index;
      int          end_ax;
      int          end_ay;
      int          end_bx;
      int          end_by;
      logic [7:0]  wall_symbol;
      logic        wall_enable;
      logic [6:0]  column;
      int          viewer_x;
      int          viewer_y;
      logic [8:0]  view_angle;
   } wall_item_type;

   typedef struct {
      logic [6:0]  column;
      logic        hit;
      logic [30:0] distance;
      logic [7:0]  symbol;
      logic [4:0]  half_height;
   } column_view_type;

   class column_scoreboard;
      int          wall_ends [MAX_WALLS_DEF][4];
      logic [7:0]  wall_sym [MAX_WALLS_DEF];
      bit          wall_live [MAX_WALLS_DEF];
      longint unsigned height_factor = 65536;
      longint      nudge = 66;
      column_view_type column_queue [$];
      int          mismatches;
      int          casts;
      int          writes;
      int          hits;

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
         end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
         end
         return v;
      endfunction

      function longint round_down(longint v, int n);
         return (v + (64'sd1 <<< (n - 1))) >>> n;
      endfunction

      // Quarter-angle Taylor series in Q30, then two angle doublings.
      function void heading_cos_sin(int deg, output longint co, output longint si);
         longint unsigned q;
         longint unsigned x2;
         longint unsigned ts;
         longint unsigned tc;
         longint s;
         longint c;
         longint s2;
         q  = (longint'(deg) * 10 * (64'd1 << 30) + 1146) / 2292;
         x2 = (q * q + (64'd1 << 29)) >> 30;
         ts = q;
         tc = 64'd1 << 30;
         s  = longint'(q);
         c  = 64'sd1 <<< 30;
         for (int n = 1; n <= 12; n++) begin
            ts = ((ts * x2 + (64'd1 << 29)) >> 30) / longint'((2 * n) * (2 * n + 1));
            tc = ((tc * x2 + (64'd1 << 29)) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               s = s - longint'(ts);
               c = c - longint'(tc);
            end else begin
               s = s + longint'(ts);
               c = c + longint'(tc);
            end
         end
         for (int n = 0; n < 2; n++) begin
            s2 = round_down(2 * s * c, 30);
            c  = (64'sd1 <<< 30) - round_down(2 * s * s, 30);
            s  = s2;
         end
         co = round_down(c, 14);
         si = round_down(s, 14);
      endfunction

      function longint unsigned int_root(longint unsigned v);
         longint unsigned res;
         longint unsigned bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function int live_walls();
         int n;
         n = 0;
         foreach (wall_live[i]) n += wall_live[i];
         return n;
      endfunction

      function void set_register(int idx, logic [31:0] value);
         if (idx == 0) begin
            height_factor = value;
         end else begin
            nudge = value[15:0];
         end
      endfunction

      function column_view_type cast_column(wall_item_type it);
         column_view_type res;
         longint vx, vy, co, si, num, r;
         longint ax, ay, bx, by, x1, y1, x2, y2, dx, k, b, den, x, y, xl, xr;
         longint unsigned reach;
         longint unsigned best;
         longint unsigned a;
         bit found;
         res.column = it.column;
         found = 0;
         best = FAR_DIST;
         res.symbol = SPACE_CODE;
         res.half_height = '0;
         if (it.column < 2 * HALF_COLS) begin
            vx = it.viewer_x;
            vy = it.viewer_y;
            heading_cos_sin(it.view_angle % 360, co, si);
            num = (it.column < HALF_COLS) ? longint'(it.column) - HALF_COLS
                                          : longint'(it.column) + 1 - HALF_COLS;
            r = (longint'(HALF_COLS) * 65536) / num;
            for (int i = 0; i < MAX_WALLS_DEF; i++) begin
               if (!wall_live[i]) continue;
               ax = clamp32(longint'(wall_ends[i][0]) - vx);
               ay = clamp32(longint'(wall_ends[i][1]) - vy);
               bx = clamp32(longint'(wall_ends[i][2]) - vx);
               by = clamp32(longint'(wall_ends[i][3]) - vy);
               x1 = clamp32((ax * co - ay * si) >>> 16);
               y1 = clamp32((ax * si + ay * co) >>> 16);
               x2 = clamp32((bx * co - by * si) >>> 16);
               y2 = clamp32((bx * si + by * co) >>> 16);
               if (y1 < 0 && y2 < 0) continue;
               if (x1 == x2) x1 = clamp32(x1 - nudge);
               dx = x2 - x1;
               if (dx == 0) continue;
               k = clamp32(((y2 - y1) * 65536) / dx);
               b = clamp32(y1 - ((k * x1) >>> 16));
               den = r - k;
               if (den == 0) continue;
               x = clamp32((b * 65536) / den);
               y = clamp32((r * x) >>> 16);
               if (y < 0) continue;
               xl = x1 < x2 ? x1 : x2;
               xr = x1 < x2 ? x2 : x1;
               if (x < xl || x > xr) continue;
               reach = int_root(longint'(x * x) + longint'(y * y));
               if (reach > FAR_DIST) reach = FAR_DIST;
               if (!found || reach < best) begin
                  found = 1;
                  best = reach;
                  res.symbol = wall_sym[i];
               end
            end
         end
         if (found) begin
            a = HALF_CAP;
            if (best != 0) begin
               a = (longint'(LINES) * height_factor) / best;
               if (a > HALF_CAP) a = HALF_CAP;
            end
            res.half_height = a[4:0];
         end
         res.hit = found;
         res.distance = best[30:0];
         return res;
      endfunction

      function void note_item(wall_item_type it);
         if (it.opcode == OP_WRITE) begin
            writes++;
            wall_ends[it.wall_index] = '{it.end_ax, it.end_ay, it.end_bx, it.end_by};
            wall_sym[it.wall_index] = it.wall_symbol;
            wall_live[it.wall_index] = it.wall_enable;
         end else begin
            casts++;
            column_queue = {column_queue, cast_column(it)};
         end
      endfunction

      function void check_column(logic [55:0] data, logic user);
         column_view_type want;
         if (column_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %h hit %b", data, user);
            return;
         end
         want = column_queue.pop_front();
         hits += want.hit;
         if (data[6:0] !== want.column || user !== want.hit || data[37:7] !== want.distance
             || data[45:38] !== want.symbol || data[50:46] !== want.half_height
             || data[55:51] !== 5'd0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: column exp %0d got %0d, hit exp %b got %b",
                        want.column, data[6:0], want.hit, user);
               $display("       distance exp %h got %h, symbol exp %h got %h, half exp %0d got %0d",
                        want.distance, data[37:7], want.symbol, data[45:38],
                        want.half_height, data[50:46]);
            end
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic [223:0] req_tdata;
   logic         req_tuser;
   logic         req_tvalid;
   logic         req_tready;
   logic [55:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   column_scoreboard sb = new();
   wall_item_type offered;
   longint       cycles;
   int           hold_cycles;
   bit           rsp_took;
   bit           quiet;

   wall_segment_ray_caster u_top (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) sb.note_item(offered);
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_column(rsp_tdata, rsp_tuser);
         rsp_took = 1;
      end
   end

   // Receiver: random stalls per item, plus one long hold-off in the second phase.
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (rsp_took) begin
            stall = quiet ? 0 : $urandom_range(0, 5);
            rsp_took = 0;
         end
         if (hold_cycles > 0) begin
            rsp_tready = 0;
            hold_cycles--;
         end else if (stall > 0) begin
            rsp_tready = 0;
            stall--;
         end else begin
            rsp_tready = 1;
         end
      end
   end

   task automatic send_item(wall_item_type it);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      offered = it;
      req_tuser = it.opcode;
      req_tdata = {2'b0, it.view_angle, it.viewer_y, it.viewer_x, it.column, it.wall_enable,
                   it.wall_symbol, it.end_by, it.end_bx, it.end_ay, it.end_ax, it.wall_index};
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 0;
      while (sb.column_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_paddr = addr;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(addr / 4, value);
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   function automatic wall_item_type make_wall(int idx, int ax, int ay, int bx, int by,
                                               logic [7:0] sym, logic en);
      wall_item_type it;
      it = '{default: 0};
      it.opcode = OP_WRITE;
      it.wall_index = 5'(idx);
      it.end_ax = ax;
      it.end_ay = ay;
      it.end_bx = bx;
      it.end_by = by;
      it.wall_symbol = sym;
      it.wall_enable = en;
      return it;
   endfunction

   function automatic wall_item_type make_cast(int col, int vx, int vy, int ang);
      wall_item_type it;
      it = '{default: 0};
      it.opcode = OP_CAST;
      it.column = 7'(col);
      it.viewer_x = vx;
      it.viewer_y = vy;
      it.view_angle = 9'(ang);
      return it;
   endfunction

   // Mostly coordinates near the origin, now and then any 32-bit value.
   function automatic int coord(int span);
      if ($urandom_range(0, 15) == 0) return $urandom;
      return int'($urandom_range(0, 2 * span * 65536)) - span * 65536;
   endfunction

   function automatic wall_item_type random_item();
      wall_item_type it;
      it.wall_index = 5'($urandom);
      it.end_ax = $urandom;
      it.end_ay = $urandom;
      it.end_bx = $urandom;
      it.end_by = $urandom;
      it.wall_symbol = 8'($urandom);
      it.column = 7'($urandom);
      it.viewer_x = $urandom;
      it.viewer_y = $urandom;
      it.view_angle = 9'($urandom);
      it.wall_enable = 1'($urandom);
      if ($urandom_range(0, 99) < 45) begin
         it.opcode = OP_CAST;
         if ($urandom_range(0, 15) != 0) it.column = 7'($urandom_range(0, 79));
         if ($urandom_range(0, 15) != 0) it.view_angle = 9'($urandom_range(0, 359));
         it.viewer_x = coord(4);
         it.viewer_y = coord(4);
      end else begin
         it.opcode = OP_WRITE;
         it.end_ax = coord(16);
         it.end_ay = coord(16);
         it.end_bx = ($urandom_range(0, 7) == 0) ? it.end_ax : coord(16);
         it.end_by = coord(16);
         // Keep casts short: only a few walls stay live at once.
         if (!sb.wall_live[it.wall_index] && sb.live_walls() >= MAX_LIVE) it.wall_enable = 0;
         else it.wall_enable = ($urandom_range(0, 2) != 0);
      end
      return it;
   endfunction

   initial begin
      wall_item_type dir [$];
      cycles = 0;
      hold_cycles = 0;
      rsp_took = 0;
      quiet = 0;
      reset = 1;
      req_tvalid = 0;
      req_tuser = 0;
      req_tdata = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      offered = '{default: 0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part, with the register values from reset.
      dir = {dir, make_cast(40, 0, 0, 0)};
      dir = {dir, make_wall(0, -5 * 65536, 8 * 65536, 5 * 65536, 8 * 65536, 8'h23, 1)};
      dir = {dir, make_wall(31, 3 * 65536, -2 * 65536, 3 * 65536, 6 * 65536, 8'hFF, 1)};
      dir = {dir, make_wall(5, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh7FFF_FFFF, 8'h00, 1)};
      dir = {dir, make_wall(7, 65536, -9 * 65536, 4 * 65536, -3 * 65536, 8'h41, 1)};
      dir = {dir, make_cast(0, 0, 0, 0)};
      dir = {dir, make_cast(39, 0, 0, 0)};
      dir = {dir, make_cast(40, 0, 0, 0)};
      dir = {dir, make_cast(79, 0, 0, 0)};
      dir = {dir, make_cast(60, 0, 0, 90)};
      dir = {dir, make_cast(20, 65536, 65536, 359)};
      dir = {dir, make_cast(45, 0, 0, 511)};
      dir = {dir, make_cast(80, 0, 0, 0)};
      dir = {dir, make_cast(127, 0, 0, 0)};
      dir = {dir, make_cast(10, 32'sh7FFF_FFFF, 32'sh8000_0000, 180)};
      dir = {dir, make_cast(70, 32'sh8000_0000, 32'sh7FFF_FFFF, 270)};
      dir = {dir, make_wall(5, 0, 0, 0, 0, 8'h00, 0)};
      dir = {dir, make_wall(3, 0, 65536, 65536, 65536, 8'h2A, 1)};
      dir = {dir, make_cast(40, 0, 65536, 0)};
      dir = {dir, make_cast(41, 65536 / 2, 0, 45)};
      dir = {dir, make_wall(3, 0, 0, 0, 0, 8'h00, 0)};
      dir = {dir, make_cast(40, 0, 0, 0)};
      foreach (dir[i]) send_item(dir[i]);

      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               csr_write(3'd0, 32'd0);
               csr_write(3'd4, 32'd0);
            end
            1: begin
               csr_write(3'd0, 32'hFFFF_FFFF);
               csr_write(3'd4, 32'h0000_FFFF);
            end
            2: begin
               csr_write(3'd0, $urandom);
               csr_write(3'd4, $urandom_range(0, 65535));
            end
            default: begin
               csr_write(3'd0, $urandom_range(1, 8) * 65536);
               csr_write(3'd4, 32'd66);
            end
         endcase
         // Directed cast against a vertical wall under this nudge setting.
         send_item(make_wall(9, 2 * 65536, -65536, 2 * 65536, 7 * 65536, 8'h7C, 1));
         send_item(make_cast(50, 0, 0, 0));
         send_item(make_wall(9, 0, 0, 0, 0, 8'h00, 0));
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (phase == 1 && n == 200) hold_cycles = 3000;
            if (phase == 2 && n == 200) begin
               @(negedge clock);
               req_tvalid = 0;
               while (sb.column_queue.size() != 0) @(negedge clock);
            end
            send_item(random_item());
         end
      end

      @(negedge clock);
      req_tvalid = 0;
      while (sb.column_queue.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      $display("Covered %0d wall writes and %0d casts, %0d of them hitting a wall,",
               sb.writes, sb.casts, sb.hits);
      $display("across four register settings including both extremes.");
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/wsrc_pkg.sv
sv/wsrc_wall_mem.sv
sv/wsrc_div.sv
sv/wsrc_sqrt.sv
sv/wall_segment_ray_caster.sv
verif/wall_segment_ray_caster_tb.sv
